@@ rtl/usbdst_pkg.sv @@
// ----------------------------------------------------------------------------
// usbdst_pkg
// Shared types and constants for the USB device state tracker.
// ----------------------------------------------------------------------------
package usbdst_pkg;

    localparam int NUM_ENDPOINTS = 16;
    // Endpoint numbers are 4 bits; compare in 5 bits so sixteen fits.
    localparam logic [4:0] EP_LIMIT = 5'(NUM_ENDPOINTS);
    localparam logic [7:0] ADDRESS_LIMIT = 8'd128;
    // Control word written to endpoint 0 when a bus reset re-arms it.
    localparam logic [7:0] EP0_CONTROL_WORD = 8'h16;

    // Register indexes on the configuration port (paddr[2]).
    localparam logic REG_CONFIG_HANDLER = 1'b0;
    localparam logic REG_DATA_HANDLER   = 1'b1;

    typedef enum logic [2:0] {
        OP_ATTACH     = 3'd0,
        OP_DETACH     = 3'd1,
        OP_BUS_RESET  = 3'd2,
        OP_XACT       = 3'd3,
        OP_SET_ADDR   = 3'd4,
        OP_SET_CONFIG = 3'd5
    } opcode_t;

    typedef enum logic [2:0] {
        ST_UNATTACHED = 3'd0,
        ST_ATTACHED   = 3'd1,
        ST_DEFAULT    = 3'd2,
        ST_ADDRESSED  = 3'd3,
        ST_CONFIGURED = 3'd4
    } dev_state_t;

    typedef enum logic [2:0] {
        STATUS_OK         = 3'd0,
        STATUS_BAD_PARAM  = 3'd1,
        STATUS_BAD_STATE  = 3'd2,
        STATUS_NO_HANDLER = 3'd3,
        STATUS_REFUSED    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ROUTE_NONE    = 2'd0,
        ROUTE_CONTROL = 2'd1,
        ROUTE_APP     = 2'd2
    } route_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic [3:0] endpoint_number;
        logic [7:0] new_address;
        logic [7:0] config_number;
        logic       handler_accepts;
    } event_t;

    typedef struct packed {
        status_t    status;
        dev_state_t state;
        logic [6:0] address;
        route_t     route;
        logic       endpoints_reset;
        logic       bus_enable;
    } result_t;

endpackage

@@ rtl/usbdst_fsm.sv @@
// ----------------------------------------------------------------------------
// usbdst_fsm
// Device state and address registers with the per-event update logic.
// ----------------------------------------------------------------------------
module usbdst_fsm (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                commit,
    input  usbdst_pkg::event_t  ev,
    input  logic                config_handler,
    input  logic                data_handler,
    output usbdst_pkg::result_t res
);

    usbdst_pkg::dev_state_t state_reg;
    usbdst_pkg::dev_state_t state_next;
    logic [6:0]             address_reg;
    logic [6:0]             address_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= usbdst_pkg::ST_UNATTACHED;
            address_reg <= 7'd0;
        end
        else if (commit)
        begin
            state_reg   <= state_next;
            address_reg <= address_next;
        end
    end

    always_comb
    begin
        logic past_default;
        past_default = (state_reg == usbdst_pkg::ST_DEFAULT) ||
                       (state_reg == usbdst_pkg::ST_ADDRESSED) ||
                       (state_reg == usbdst_pkg::ST_CONFIGURED);

        state_next          = state_reg;
        address_next        = address_reg;
        res.status          = usbdst_pkg::STATUS_OK;
        res.route           = usbdst_pkg::ROUTE_NONE;
        res.endpoints_reset = 1'b0;

        unique case (usbdst_pkg::opcode_t'(ev.opcode))
            usbdst_pkg::OP_ATTACH:
            begin
                if (state_reg == usbdst_pkg::ST_UNATTACHED)
                begin
                    state_next = usbdst_pkg::ST_ATTACHED;
                end
            end
            usbdst_pkg::OP_DETACH:
            begin
                state_next = usbdst_pkg::ST_UNATTACHED;
            end
            usbdst_pkg::OP_BUS_RESET:
            begin
                if (state_reg != usbdst_pkg::ST_UNATTACHED)
                begin
                    state_next          = usbdst_pkg::ST_DEFAULT;
                    address_next        = 7'd0;
                    res.endpoints_reset = 1'b1;
                end
            end
            usbdst_pkg::OP_XACT:
            begin
                if (past_default && ({1'b0, ev.endpoint_number} < usbdst_pkg::EP_LIMIT))
                begin
                    if (ev.endpoint_number == 4'd0)
                    begin
                        res.route = usbdst_pkg::ROUTE_CONTROL;
                    end
                    else if (state_reg == usbdst_pkg::ST_CONFIGURED && data_handler)
                    begin
                        res.route = usbdst_pkg::ROUTE_APP;
                    end
                end
            end
            usbdst_pkg::OP_SET_ADDR:
            begin
                if (state_reg == usbdst_pkg::ST_DEFAULT ||
                    state_reg == usbdst_pkg::ST_ADDRESSED)
                begin
                    if (ev.new_address != 8'd0 && ev.new_address < usbdst_pkg::ADDRESS_LIMIT)
                    begin
                        address_next = ev.new_address[6:0];
                        state_next   = usbdst_pkg::ST_ADDRESSED;
                    end
                    else
                    begin
                        res.status = usbdst_pkg::STATUS_BAD_PARAM;
                    end
                end
                else
                begin
                    res.status = usbdst_pkg::STATUS_BAD_STATE;
                end
            end
            usbdst_pkg::OP_SET_CONFIG:
            begin
                priority if (state_reg != usbdst_pkg::ST_ADDRESSED &&
                             state_reg != usbdst_pkg::ST_CONFIGURED)
                begin
                    res.status = usbdst_pkg::STATUS_BAD_STATE;
                end
                else if (!config_handler)
                begin
                    res.status = usbdst_pkg::STATUS_NO_HANDLER;
                end
                else if (ev.config_number == 8'd0)
                begin
                    state_next = usbdst_pkg::ST_ADDRESSED;
                end
                else if (ev.handler_accepts)
                begin
                    state_next = usbdst_pkg::ST_CONFIGURED;
                end
                else
                begin
                    res.status = usbdst_pkg::STATUS_REFUSED;
                end
            end
            default:
            begin
                // undefined opcodes: no effect
            end
        endcase

        res.state      = state_next;
        res.address    = address_next;
        res.bus_enable = (state_next != usbdst_pkg::ST_UNATTACHED);
    end

endmodule

@@ rtl/usb_device_state_tracker_top.sv @@
// ----------------------------------------------------------------------------
// usb_device_state_tracker_top
// USB device state tracker: one bus event in, one status request out.
// ----------------------------------------------------------------------------
// Usage:
//   Event channel (ev_valid/ev_ready) carries one bus event per request:
//   attach, detach, bus reset, transaction, set address or set config.
//   Result channel (res_valid/res_ready) returns exactly one request per
//   event with status, new device state, address, routing and flags.
//   An APB port holds two 1-bit registers: set-config handler present
//   (0x0) and data handler present (0x4); pready is tied high. Write them
//   only while no event is in flight.
// Pipeline:
//   Two stages: input register, then the result register. A taken event
//   is registered in the input stage and its result in the result
//   register; one event per cycle sustained while res_ready stays high.
//   The state update sits between the two stages, so each event sees the
//   state left by the one before it.
// Reset:
//   rst_n (async, active low) empties both stages, puts the device in the
//   unattached state at address 0 and clears both handler registers.
// Stalls:
//   With res_ready low the result register holds; the input stage still
//   fills, so ev_ready drops only when both stages are full.
// ----------------------------------------------------------------------------
module usb_device_state_tracker_top (
    input  logic        clk,
    input  logic        rst_n,
    // event channel
    input  logic        ev_valid,
    output logic        ev_ready,
    input  logic [2:0]  opcode,
    input  logic [3:0]  endpoint_number,
    input  logic [7:0]  new_address,
    input  logic [7:0]  config_number,
    input  logic        handler_accepts,
    // result channel
    output logic        res_valid,
    input  logic        res_ready,
    output logic [2:0]  status,
    output logic [2:0]  device_state_out,
    output logic [6:0]  device_address_out,
    output logic [1:0]  route,
    output logic        endpoints_reset,
    output logic        bus_enable,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------- configuration registers ----------------
    logic config_handler_reg;
    logic data_handler_reg;
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            config_handler_reg <= 1'b0;
            data_handler_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == usbdst_pkg::REG_CONFIG_HANDLER)
            begin
                config_handler_reg <= pwdata[0];
            end
            else
            begin
                data_handler_reg <= pwdata[0];
            end
        end
    end

    assign prdata = {31'd0, (paddr[2] == usbdst_pkg::REG_DATA_HANDLER) ?
                            data_handler_reg : config_handler_reg};

    // ---------------- pipeline control ----------------
    // Stage 1 holds the accepted event; stage 2 the finished result.
    logic                in_valid_reg;
    usbdst_pkg::event_t  ev_reg;
    logic                out_valid_reg;
    usbdst_pkg::result_t res_reg;
    usbdst_pkg::result_t res_next;
    logic                out_free;
    logic                advance;
    logic                take;

    assign out_free = !out_valid_reg || res_ready;
    assign advance  = in_valid_reg && out_free;   // stage 1 -> stage 2
    assign ev_ready = !in_valid_reg || out_free;
    assign take     = ev_valid && ev_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ev_ready)
            begin
                in_valid_reg <= ev_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ev_reg <= '{opcode:          opcode,
                        endpoint_number: endpoint_number,
                        new_address:     new_address,
                        config_number:   config_number,
                        handler_accepts: handler_accepts};
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    // ---------------- state machine ----------------
    // State commits on the same edge the result is captured.
    usbdst_fsm u_fsm (
        .clk            (clk),
        .rst_n          (rst_n),
        .commit         (advance),
        .ev             (ev_reg),
        .config_handler (config_handler_reg),
        .data_handler   (data_handler_reg),
        .res            (res_next)
    );

    // ---------------- outputs ----------------
    assign res_valid          = out_valid_reg;
    assign status             = res_reg.status;
    assign device_state_out   = res_reg.state;
    assign device_address_out = res_reg.address;
    assign route              = res_reg.route;
    assign endpoints_reset    = res_reg.endpoints_reset;
    assign bus_enable         = res_reg.bus_enable;

    // ---------------- assertions ----------------
    // A stalled result must not be overwritten.
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_ready) |=> $stable(res_reg))
        else $error("result changed while stalled");

    // Bus reset leaves the device in default state at address 0.
    a_reset_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.endpoints_reset) |->
        (res_reg.address == 7'd0 && res_reg.state == usbdst_pkg::ST_DEFAULT))
        else $error("bus reset result inconsistent");

    // Transactions are routed only once the device is past attached.
    a_route_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.route != usbdst_pkg::ROUTE_NONE) |->
        (res_reg.state != usbdst_pkg::ST_UNATTACHED &&
         res_reg.state != usbdst_pkg::ST_ATTACHED))
        else $error("route given before default state");

    // Bus enable tracks attachment.
    a_bus_enable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
        (res_reg.bus_enable == (res_reg.state != usbdst_pkg::ST_UNATTACHED)))
        else $error("bus enable inconsistent with state");

    // Application routing requires the configured state and the data handler.
    a_app_route: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.route == usbdst_pkg::ROUTE_APP) |->
        (res_reg.state == usbdst_pkg::ST_CONFIGURED && data_handler_reg))
        else $error("application route while not configured");

endmodule
